FILE: design/flpw_pkg.sv
// Package for the four-level page walk write block.
// Store geometry, field widths, op, config and size codes, walker states, status and descriptor codes.
// No dependencies.
package flpw_pkg;

  localparam int TABLE_SLOTS       = 16;
  localparam int SLOT_BITS         = $clog2(TABLE_SLOTS);
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_BITS          = $clog2(ENTRIES_PER_TABLE);
  localparam int STORE_DEPTH       = TABLE_SLOTS * ENTRIES_PER_TABLE;
  localparam int ADDR_BITS         = $clog2(STORE_DEPTH);
  localparam int PHYS_BITS         = 40;
  localparam int ENTRY_BITS        = 40;
  localparam int PAGE_BITS         = 12;
  localparam int FRAME_BITS        = 28;
  localparam int LIMIT_BITS        = 29;
  localparam int VA_BITS           = 48;
  localparam int DATA_BITS         = 64;
  localparam int SIZE_BITS         = 2;
  localparam int LEVEL_BITS        = 2;
  localparam int IN_TDATA_BITS     = 192;
  localparam int OUT_TDATA_BITS    = 112;
  localparam int CFG_DATA_BITS     = 29;

  localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [1:0] DESC_BLOCK = 2'd1;
  localparam logic [1:0] DESC_TABLE = 2'd3;

  localparam logic [SIZE_BITS-1:0] SZ_BYTE  = 2'd0;
  localparam logic [SIZE_BITS-1:0] SZ_HALF  = 2'd1;
  localparam logic [SIZE_BITS-1:0] SZ_WORD  = 2'd2;
  localparam logic [SIZE_BITS-1:0] SZ_DOUBLE = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    STAT_PAGE      = 2'd0,
    STAT_BLOCK     = 2'd1,
    STAT_INVALID   = 2'd2,
    STAT_BAD_FRAME = 2'd3
  } status_t;

endpackage

FILE: design/four_level_page_walk_write.sv
// Top level of the four-level page walk write block.
// Descriptor store, walk sequencer and result register; uses flpw_pkg.
//
// After reset the block clears its 8192-entry descriptor store, one entry a
// cycle, and takes no word until the clear is done (configuration writes
// are taken). A load word writes its entry into the store. A write request
// issues the level-0 read, then one more read per table level visited: the
// descriptor reads, up to four, are dependent and share the single read
// port of the store. The result sits in an output register, so the next
// word is taken while it waits.
module four_level_page_walk_write
  import flpw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // table_frame[27:0], entry_index[36:28], entry_word[76:37], virt_addr[124:77],
  // data_value[188:125], size_code[190:189], zero pad
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,
  // op
  input  logic                      in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // phys_addr[39:0], write_data[103:40], write_size[105:104], stop_level[107:106],
  // zero pad
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  // status
  output logic [1:0]                out_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [ENTRY_BITS-1:0] mem [STORE_DEPTH];

  state_t                 state_r, state_nxt;
  logic [ADDR_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [LEVEL_BITS-1:0]  level_r, level_nxt;
  logic [VA_BITS-1:0]     va_r, va_nxt;
  logic [DATA_BITS-1:0]   data_r, data_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [FRAME_BITS-1:0]  root_r, root_nxt;
  logic [LIMIT_BITS-1:0]  limit_r, limit_nxt;
  logic [ENTRY_BITS-1:0]  rd_data_r;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [PHYS_BITS-1:0]   out_pa_r, out_pa_nxt;
  logic [DATA_BITS-1:0]   out_data_r, out_data_nxt;
  logic [SIZE_BITS-1:0]   out_size_r, out_size_nxt;
  logic [LEVEL_BITS-1:0]  out_level_r, out_level_nxt;

  logic                   wr_en, rd_en;
  logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
  logic [ENTRY_BITS-1:0]  wr_data;

  logic [FRAME_BITS-1:0]  in_frame;
  logic [IDX_BITS-1:0]    in_idx;
  logic [ENTRY_BITS-1:0]  in_entry;
  logic [VA_BITS-1:0]     in_va;
  logic [DATA_BITS-1:0]   in_data;
  logic [SIZE_BITS-1:0]   in_size;

  logic [1:0]             desc_type;
  logic                   descend, out_free;
  logic [PHYS_BITS-1:0]   ofs_mask, page_pa, block_pa;
  logic [DATA_BITS-1:0]   trunc_data;

  function automatic logic [IDX_BITS-1:0] level_index(logic [VA_BITS-1:0] va,
                                                      logic [LEVEL_BITS-1:0] lvl);
    logic [IDX_BITS-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  assign in_frame = in_tdata[27:0];
  assign in_idx   = in_tdata[36:28];
  assign in_entry = in_tdata[76:37];
  assign in_va    = in_tdata[124:77];
  assign in_data  = in_tdata[188:125];
  assign in_size  = in_tdata[190:189];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_level_r, out_size_r, out_data_r, out_pa_r};

  assign desc_type = rd_data_r[1:0];
  assign descend   = (level_r != LAST_LEVEL) && (desc_type == DESC_TABLE);
  assign out_free  = !out_valid_r || out_tready;
  assign page_pa   = {rd_data_r[PHYS_BITS-1:PAGE_BITS], va_r[PAGE_BITS-1:0]};
  assign block_pa  = (rd_data_r[PHYS_BITS-1:0] & ~ofs_mask) | (va_r[PHYS_BITS-1:0] & ofs_mask);

  always_comb begin
    case (level_r)
      2'd0:    ofs_mask = {1'b0, {39{1'b1}}};
      2'd1:    ofs_mask = {10'b0, {30{1'b1}}};
      default: ofs_mask = {19'b0, {21{1'b1}}};
    endcase
  end

  always_comb begin
    case (size_r)
      SZ_BYTE: trunc_data = {56'b0, data_r[7:0]};
      SZ_HALF: trunc_data = {48'b0, data_r[15:0]};
      SZ_WORD: trunc_data = {32'b0, data_r[31:0]};
      default: trunc_data = data_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    level_nxt      = level_r;
    va_nxt         = va_r;
    data_nxt       = data_r;
    size_nxt       = size_r;
    root_nxt       = root_r;
    limit_nxt      = limit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pa_nxt     = out_pa_r;
    out_data_nxt   = out_data_r;
    out_size_nxt   = out_size_r;
    out_level_nxt  = out_level_r;
    wr_en          = 1'b0;
    wr_addr        = clr_addr_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = {root_r[SLOT_BITS-1:0], level_index(in_va, 2'd0)};

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROOT:  root_nxt  = cfg_data[FRAME_BITS-1:0];
        CFG_LIMIT: limit_nxt = cfg_data;
        default:   ;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_BITS'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_LOAD) begin
            wr_en   = 1'b1;
            wr_addr = {in_frame[SLOT_BITS-1:0], in_idx};
            wr_data = in_entry;
          end else begin
            rd_en     = 1'b1;
            level_nxt = '0;
            va_nxt    = in_va;
            data_nxt  = in_data;
            size_nxt  = in_size;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (descend) begin
          rd_en     = 1'b1;
          rd_addr   = {rd_data_r[PAGE_BITS +: SLOT_BITS],
                       level_index(va_r, level_r + 1'b1)};
          level_nxt = level_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_size_nxt  = size_r;
          out_level_nxt = level_r;
          out_pa_nxt    = '0;
          out_data_nxt  = '0;
          if (level_r == LAST_LEVEL) begin
            if (desc_type != DESC_TABLE) begin
              out_status_nxt = STAT_INVALID;
            end else if ({1'b0, rd_data_r[PHYS_BITS-1:PAGE_BITS]} >= limit_r) begin
              out_status_nxt = STAT_BAD_FRAME;
            end else begin
              out_status_nxt = STAT_PAGE;
              out_pa_nxt     = page_pa;
              out_data_nxt   = trunc_data;
            end
          end else if (desc_type == DESC_BLOCK) begin
            out_status_nxt = STAT_BLOCK;
            out_pa_nxt     = block_pa;
            out_data_nxt   = trunc_data;
          end else begin
            out_status_nxt = STAT_INVALID;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      root_r      <= '0;
      limit_r     <= LIMIT_BITS'(1) << (LIMIT_BITS - 1);
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      root_r      <= root_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r      <= level_nxt;
    va_r         <= va_nxt;
    data_r       <= data_nxt;
    size_r       <= size_nxt;
    out_status_r <= out_status_nxt;
    out_pa_r     <= out_pa_nxt;
    out_data_r   <= out_data_nxt;
    out_size_r   <= out_size_nxt;
    out_level_r  <= out_level_nxt;
  end

endmodule

FILE: design/flpw_checker.sv
// Port-level checker for the four-level page walk write block, with its bind.
// Watches the result channel and the input ready; uses flpw_pkg.
module flpw_checker
  import flpw_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic [1:0]                out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_INVALID || out_tuser == STAT_BAD_FRAME)
      |-> out_tdata[103:0] == '0)
    else $error("fault result carries address or data");

  a_page_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_PAGE || out_tuser == STAT_BAD_FRAME)
      |-> out_tdata[107:106] == LAST_LEVEL)
    else $error("page result not at last level");

  a_block_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_BLOCK |-> out_tdata[107:106] != LAST_LEVEL)
    else $error("block result at last level");

  a_clear_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during store clear");

endmodule

bind four_level_page_walk_write flpw_checker u_flpw_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for four_level_page_walk_write: loads descriptor tables, issues translated
// writes and checks every result word against a page-walk scoreboard.
// Depends on flpw_pkg and the four_level_page_walk_write RTL.
module tb_top;
  import flpw_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RST_CYCLES   = 9;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1900;
  localparam int NUM_PHASES   = 6;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = 29'h1000_0000;

  localparam logic [1:0] DESC_NONE     = 2'd0;
  localparam logic [1:0] DESC_RESERVED = 2'd2;

  localparam int DATA_LSB  = PHYS_BITS;
  localparam int SIZE_LSB  = DATA_LSB + DATA_BITS;
  localparam int LEVEL_LSB = SIZE_LSB + SIZE_BITS;

  typedef struct packed {
    status_t               status;
    logic [PHYS_BITS-1:0]  phys_addr;
    logic [DATA_BITS-1:0]  write_data;
    logic [SIZE_BITS-1:0]  write_size;
    logic [LEVEL_BITS-1:0] stop_level;
  } write_result_t;

  class walk_scoreboard;
    logic [ENTRY_BITS-1:0] desc_mem [STORE_DEPTH];
    logic [FRAME_BITS-1:0] root_frame;
    logic [LIMIT_BITS-1:0] frame_limit;
    write_result_t         expected_writes[$];
    int                    errors;

    function new();
      foreach (desc_mem[i]) desc_mem[i] = '0;
      root_frame  = '0;
      frame_limit = LIMIT_MAX;
      errors      = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_BITS-1:0] value);
      if (idx == CFG_ROOT) begin
        root_frame = value[FRAME_BITS-1:0];
      end else begin
        frame_limit = value;
      end
    endfunction

    function int slot_addr(logic [FRAME_BITS-1:0] frame, logic [IDX_BITS-1:0] idx);
      return int'(frame % TABLE_SLOTS) * ENTRIES_PER_TABLE + int'(idx);
    endfunction

    function void note_word(logic op, logic [FRAME_BITS-1:0] frame,
                            logic [IDX_BITS-1:0] idx, logic [ENTRY_BITS-1:0] word,
                            logic [VA_BITS-1:0] va, logic [DATA_BITS-1:0] data,
                            logic [SIZE_BITS-1:0] size);
      write_result_t         res;
      logic [FRAME_BITS-1:0] walk_frame;
      logic [ENTRY_BITS-1:0] desc;
      logic [PHYS_BITS-1:0]  off_mask;
      int                    shift;
      if (op == OP_LOAD) begin
        desc_mem[slot_addr(frame, idx)] = word;
        return;
      end
      res.status     = STAT_INVALID;
      res.phys_addr  = '0;
      res.write_data = '0;
      res.write_size = size;
      res.stop_level = '0;
      walk_frame     = root_frame;
      for (int lvl = 0; lvl < 4; lvl++) begin
        shift = PAGE_BITS + (3 - lvl) * IDX_BITS;
        desc  = desc_mem[slot_addr(walk_frame, IDX_BITS'(va >> shift))];
        res.stop_level = LEVEL_BITS'(lvl);
        if (lvl == LAST_LEVEL) begin
          if (desc[1:0] == DESC_TABLE) begin
            if ({1'b0, desc[PHYS_BITS-1:PAGE_BITS]} >= frame_limit) begin
              res.status = STAT_BAD_FRAME;
            end else begin
              res.status    = STAT_PAGE;
              res.phys_addr = {desc[PHYS_BITS-1:PAGE_BITS], va[PAGE_BITS-1:0]};
            end
          end
          break;
        end
        if (desc[1:0] == DESC_TABLE) begin
          walk_frame = desc[PHYS_BITS-1:PAGE_BITS];
          continue;
        end
        if (desc[1:0] == DESC_BLOCK) begin
          off_mask      = (PHYS_BITS'(1) << shift) - PHYS_BITS'(1);
          res.status    = STAT_BLOCK;
          res.phys_addr = (desc & ~off_mask) | (va[PHYS_BITS-1:0] & off_mask);
        end
        break;
      end
      if (res.status == STAT_PAGE || res.status == STAT_BLOCK) begin
        case (size)
          SZ_BYTE: res.write_data = {56'b0, data[7:0]};
          SZ_HALF: res.write_data = {48'b0, data[15:0]};
          SZ_WORD: res.write_data = {32'b0, data[31:0]};
          default: res.write_data = data;
        endcase
      end
      expected_writes.push_back(res);
    endfunction

    function void check_field(string name, logic [DATA_BITS-1:0] exp_v,
                              logic [DATA_BITS-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [1:0] status, logic [OUT_TDATA_BITS-1:0] tdata);
      write_result_t exp_res;
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual status %h data %h",
                 $time, status, tdata);
        return;
      end
      exp_res = expected_writes.pop_front();
      check_field("status", 64'(exp_res.status), 64'(status));
      check_field("phys_addr", 64'(exp_res.phys_addr), 64'(tdata[PHYS_BITS-1:0]));
      check_field("write_data", exp_res.write_data, tdata[DATA_LSB +: DATA_BITS]);
      check_field("write_size", 64'(exp_res.write_size), 64'(tdata[SIZE_LSB +: SIZE_BITS]));
      check_field("stop_level", 64'(exp_res.stop_level),
                  64'(tdata[LEVEL_LSB +: LEVEL_BITS]));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;
  logic                      in_tuser = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic [1:0]                out_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_index = 1'b0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  walk_scoreboard sb = new();
  int             cycle_count = 0;
  int             words_sent = 0;
  int             tx_burst_left = 0;
  bit             hold_req = 1'b0;

  four_level_page_walk_write u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IDX_BITS-1:0] va_index(logic [VA_BITS-1:0] va, int lvl);
    return IDX_BITS'(va >> (PAGE_BITS + (3 - lvl) * IDX_BITS));
  endfunction

  // mostly back-to-back, some short gaps, a few long ones, and gap-free stretches
  function automatic int pick_tx_gap();
    int r;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      tx_burst_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic op, logic [FRAME_BITS-1:0] frame,
                           logic [IDX_BITS-1:0] idx, logic [ENTRY_BITS-1:0] word,
                           logic [VA_BITS-1:0] va, logic [DATA_BITS-1:0] data,
                           logic [SIZE_BITS-1:0] size);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_BITS'({size, data, va, word, idx, frame});
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_word(op, frame, idx, word, va, data, size);
    words_sent++;
    gap = pick_tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry junk that the block must ignore
  task automatic load_entry(logic [FRAME_BITS-1:0] frame, logic [IDX_BITS-1:0] idx,
                            logic [ENTRY_BITS-1:0] word);
    send_word(OP_LOAD, frame, idx, word, VA_BITS'(rnd64()), rnd64(), SIZE_BITS'($urandom));
  endtask

  task automatic translate(logic [VA_BITS-1:0] va, logic [DATA_BITS-1:0] data,
                           logic [SIZE_BITS-1:0] size);
    send_word(OP_WRITE, FRAME_BITS'($urandom), IDX_BITS'($urandom),
              ENTRY_BITS'(rnd64()), va, data, size);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, value);
  endtask

  task automatic set_config(logic [FRAME_BITS-1:0] root, logic [LIMIT_BITS-1:0] limit);
    wait_results();
    cfg_write(CFG_ROOT, CFG_DATA_BITS'(root));
    cfg_write(CFG_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // builds a walk from the root down to a chosen level, then translates through it
  task automatic walk_sequence(logic [FRAME_BITS-1:0] root, logic [LIMIT_BITS-1:0] limit);
    logic [VA_BITS-1:0]    va;
    logic [VA_BITS-1:0]    ofs_mask;
    logic [FRAME_BITS-1:0] frame;
    logic [FRAME_BITS-1:0] next_frame;
    logic [FRAME_BITS-1:0] leaf_frame;
    logic [ENTRY_BITS-1:0] leaf;
    int                    stop;
    int                    reps;
    va    = VA_BITS'(rnd64());
    stop  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
    frame = root;
    for (int lvl = 0; lvl < stop; lvl++) begin
      next_frame = FRAME_BITS'($urandom);
      load_entry(frame, va_index(va, lvl), {next_frame, 10'($urandom), DESC_TABLE});
      frame = next_frame;
    end
    leaf = ENTRY_BITS'(rnd64());
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: leaf[1:0] = DESC_NONE;
        1: leaf[1:0] = DESC_RESERVED;
        default: leaf[1:0] = (stop == LAST_LEVEL) ? DESC_BLOCK : DESC_NONE;
      endcase
    end else if (stop == LAST_LEVEL) begin
      case ($urandom_range(0, 2))
        0: leaf_frame = FRAME_BITS'($urandom);
        1: leaf_frame = FRAME_BITS'(limit - 1'b1);
        default: leaf_frame = FRAME_BITS'(limit);
      endcase
      leaf = {leaf_frame, leaf[PAGE_BITS-1:2], DESC_TABLE};
    end else begin
      leaf[1:0] = DESC_BLOCK;
    end
    load_entry(frame, va_index(va, stop), leaf);
    ofs_mask = (VA_BITS'(1) << (PAGE_BITS + (3 - stop) * IDX_BITS)) - VA_BITS'(1);
    reps = $urandom_range(1, 3);
    repeat (reps) begin
      va = (va & ~ofs_mask) | (VA_BITS'(rnd64()) & ofs_mask);
      translate(va, rnd64(), SIZE_BITS'($urandom));
    end
  endtask

  initial begin
    int stall_left;
    int burst_left;
    int r;
    bit hold_done;
    stall_left = 0;
    burst_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tuser, out_tdata);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
        burst_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          burst_left = $urandom_range(20, 120);
          out_tready <= 1'b1;
        end else if (r < 33) begin
          stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    logic [FRAME_BITS-1:0] root;
    logic [LIMIT_BITS-1:0] limit;
    int                    phase_end;
    int                    r;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty store: root entries read as zero
    translate(48'h0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, SZ_DOUBLE);
    translate(48'hFFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, SZ_BYTE);
    // level-0 block
    load_entry(28'h0, 9'd0, 40'hFF_FFFF_FFFD);
    translate(48'h007F_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, SZ_HALF);
    translate(48'h0000_0000_0000, 64'h0, SZ_WORD);
    // full walk down the top index of every level to the highest page frame
    load_entry(28'h0, 9'd511, {28'hFFF_FFFF, 10'h000, DESC_TABLE});
    load_entry(28'hFFF_FFFF, 9'd511, {28'h000_0001, 10'h3FF, DESC_TABLE});
    load_entry(28'h000_0001, 9'd511, {28'h000_0002, 10'h000, DESC_TABLE});
    load_entry(28'h000_0002, 9'd511, {28'hFFF_FFFF, 10'h3FF, DESC_TABLE});
    translate(48'hFFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, SZ_BYTE);
    translate(48'hFFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, SZ_HALF);
    translate(48'hFFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, SZ_WORD);
    translate(48'hFFFF_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, SZ_DOUBLE);
    // unwritten last-level entry
    translate(48'hFFFF_FFE0_0FFF, rnd64(), SZ_DOUBLE);
    // reserved type at level 1, block at level 1 and level 2
    load_entry(28'hFFF_FFFF, 9'd0, {38'h0, DESC_RESERVED});
    translate(48'hFF80_0012_3456, rnd64(), SZ_WORD);
    load_entry(28'hFFF_FFFF, 9'd1, 40'hAB_CDEF_1235);
    translate(48'hFF80_7FFF_FFFF, rnd64(), SZ_DOUBLE);
    load_entry(28'h000_0001, 9'd0, 40'h12_3456_7891);
    translate(48'hFFFF_C01F_FFFF, rnd64(), SZ_HALF);
    // block type at the last level faults
    load_entry(28'h000_0002, 9'd5, 40'h55_5555_5001);
    translate(48'hFFFF_FFE0_5ABC, rnd64(), SZ_BYTE);
    // frame 0x10 aliases the root slot
    load_entry(28'h000_0010, 9'd511, 40'h7F_0000_0001);
    translate(48'hFFFF_FFFF_FFFF, rnd64(), SZ_DOUBLE);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin root = '0; limit = LIMIT_MAX; end
        1: begin root = '1; limit = '0; end
        2: begin
          root  = FRAME_BITS'($urandom);
          limit = LIMIT_BITS'($urandom_range(1, LIMIT_MAX - 1));
        end
        3: begin root = FRAME_BITS'($urandom); limit = LIMIT_MAX - 1'b1; end
        4: begin root = FRAME_BITS'($urandom); limit = 29'd1; end
        default: begin
          root  = FRAME_BITS'($urandom);
          limit = LIMIT_BITS'($urandom_range(0, LIMIT_MAX));
        end
      endcase
      set_config(root, limit);
      if (ph == 3) begin
        // output held off while words keep coming, so the input backs up
        hold_req      = 1'b1;
        tx_burst_left = 100;
      end
      phase_end = words_sent + RANDOM_WORDS / NUM_PHASES;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          walk_sequence(root, limit);
        end else if (r < 90) begin
          load_entry(FRAME_BITS'($urandom), IDX_BITS'($urandom), ENTRY_BITS'(rnd64()));
        end else begin
          translate(VA_BITS'(rnd64()), rnd64(), SIZE_BITS'($urandom));
        end
        if ($urandom_range(0, 49) == 0)
          wait_results();
      end
    end

    wait_results();
    if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/flpw_pkg.sv
design/four_level_page_walk_write.sv
design/flpw_checker.sv
bench/tb_top.sv
